// ===== design/amh_pkg.sv =====
// Package for the AES-MMO Merkle node hash unit: domain constants, request codes,
// and the AES-128 round functions used by the cipher core. No dependencies.
`timescale 1ns / 1ps

package amh_pkg;

    localparam logic [127:0] LEAF_DOMAIN  = 128'h564f4c456974482d_4c65616600000000;
    localparam logic [127:0] INODE_DOMAIN = 128'h564f4c456974482d_4e6f646500000000;
    localparam logic [7:0]   PAD_BYTE     = 8'h80;
    localparam logic [4:0]   FULL_BYTES   = 5'd16;

    localparam logic REQ_LEAF  = 1'b0;
    localparam logic REQ_INODE = 1'b1;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_MALFORMED = 1'b1;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [10] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    // Byte i of a 128-bit word sits in bits 127-8i downto 120-8i.
    function automatic logic [7:0] get_byte(input logic [127:0] w, input int i);
        return w[127 - 8 * i -: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[127 - 8 * (i + 4 * c) -: 8] = SBOX[get_byte(s, i + 4 * ((c + i) % 4))];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] t);
        logic [127:0] s;
        logic [7:0] a0, a1, a2, a3;
        s = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(t, 4 * c);
            a1 = get_byte(t, 4 * c + 1);
            a2 = get_byte(t, 4 * c + 2);
            a3 = get_byte(t, 4 * c + 3);
            s[127 - 32 * c -: 8]  = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            s[119 - 32 * c -: 8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            s[111 - 32 * c -: 8]  = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            s[103 - 32 * c -: 8]  = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        return s;
    endfunction

    function automatic logic [127:0] next_round_key(input logic [127:0] k, input int r);
        logic [31:0] w0, w1, w2, w3, tw;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        tw = {SBOX[w3[23:16]] ^ RCON[r], SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ tw;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

// ===== design/amh_aes_round.sv =====
// One AES-128 round together with its key expansion step.
// Depends on amh_pkg for the S-box and round functions.
`timescale 1ns / 1ps

module amh_aes_round #(
    parameter int ROUND = 1
) (
    input  logic [127:0] state_in,
    input  logic [127:0] key_in,
    output logic [127:0] state_out,
    output logic [127:0] key_out
);

    logic [127:0] shifted;

    always_comb
    begin
        key_out = amh_pkg::next_round_key(key_in, ROUND - 1);
        shifted = amh_pkg::sub_shift(state_in);
        if (ROUND < 10)
        begin
            state_out = amh_pkg::mix_columns(shifted) ^ key_out;
        end
        else
        begin
            state_out = shifted ^ key_out;
        end
    end

endmodule

// ===== design/amh_mmo_core.sv =====
// Matyas-Meyer-Oseas compression AES(key, m) XOR m over ten unrolled rounds.
// Depends on amh_pkg and amh_aes_round.
`timescale 1ns / 1ps

module amh_mmo_core (
    input  logic [127:0] key,
    input  logic [127:0] msg,
    output logic [127:0] hash
);

    logic [127:0] st [11];
    logic [127:0] rk [11];

    assign st[0] = msg ^ key;
    assign rk[0] = key;

    for (genvar r = 1; r <= 10; r++)
    begin : g_round
        amh_aes_round #(.ROUND(r)) u_round (
            .state_in  (st[r - 1]),
            .key_in    (rk[r - 1]),
            .state_out (st[r]),
            .key_out   (rk[r])
        );
    end

    assign hash = st[10] ^ msg;

endmodule

// ===== design/aes_mmo_merkle_node_hash_unit.sv =====
// Top level of the AES-MMO Merkle node hash unit.
// Depends on amh_pkg and amh_mmo_core.
`timescale 1ns / 1ps

// Each accepted transaction yields exactly one result transaction. An item is
// registered at the input, the full ten-round AES-128 and the feed-forward XOR
// run in the following cycle, and the result lands in an output register;
// one item is taken every cycle while the output is not stalled. This rate
// rests on the leaf chain: the next block's key is this block's hash, so the
// whole cipher sits between the input register and the chain register. In leaf
// mode the chain starts from the leaf domain constant and is restarted on a
// completed or malformed message; inode requests leave the chain untouched.
// The output register may hold a result while the input register holds the
// next item, and both advance together whenever the output is not stalled.
module aes_mmo_merkle_node_hash_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic         req_type,
    input  logic [63:0]  block_hi,
    input  logic [63:0]  block_lo,
    input  logic [63:0]  right_hi,
    input  logic [63:0]  right_lo,
    input  logic [4:0]   block_bytes,
    input  logic         last_block,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [63:0]  digest_hi,
    output logic [63:0]  digest_lo,
    output logic         digest_valid,
    output logic         status
);

    // Input register.
    logic         s1_valid_reg;
    logic         req_reg;
    logic [127:0] blk_reg;
    logic [127:0] right_reg;
    logic [4:0]   nbytes_reg;
    logic         last_reg;

    // Chain state.
    logic [127:0] chain_reg, chain_next;
    logic         in_msg_reg, in_msg_next;

    // Output register.
    logic         out_valid_reg;
    logic [127:0] dig_reg, dig_next;
    logic         dvalid_reg, dvalid_next;
    logic         status_reg, status_next;

    logic         advance;
    logic         s1_free;
    logic         malformed;
    logic [127:0] key, msg, padded, hash;

    // The stage advances when the output slot is empty or being drained.
    assign advance  = !out_valid_reg || !out_stall;
    assign s1_free  = !s1_valid_reg || advance;
    assign in_stall = !s1_free;

    assign malformed = (nbytes_reg > amh_pkg::FULL_BYTES)
                    || (!last_reg && nbytes_reg != amh_pkg::FULL_BYTES)
                    || (last_reg && nbytes_reg == 5'd0 && in_msg_reg);

    // Bytes past the count are cleared, the pad byte follows the last one.
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            if (5'(i) < nbytes_reg)
            begin
                padded[127 - 8 * i -: 8] = blk_reg[127 - 8 * i -: 8];
            end
            else if (5'(i) == nbytes_reg)
            begin
                padded[127 - 8 * i -: 8] = amh_pkg::PAD_BYTE;
            end
            else
            begin
                padded[127 - 8 * i -: 8] = 8'h00;
            end
        end
    end

    assign key = (req_reg == amh_pkg::REQ_INODE) ? blk_reg : chain_reg;
    assign msg = (req_reg == amh_pkg::REQ_INODE) ? (right_reg ^ amh_pkg::INODE_DOMAIN)
                                                 : padded;

    amh_mmo_core u_core (
        .key  (key),
        .msg  (msg),
        .hash (hash)
    );

    always_comb
    begin
        chain_next  = chain_reg;
        in_msg_next = in_msg_reg;
        dig_next    = '0;
        dvalid_next = 1'b0;
        status_next = amh_pkg::STATUS_OK;
        if (req_reg == amh_pkg::REQ_INODE)
        begin
            dig_next    = hash;
            dvalid_next = 1'b1;
        end
        else if (malformed)
        begin
            chain_next  = amh_pkg::LEAF_DOMAIN;
            in_msg_next = 1'b0;
            status_next = amh_pkg::STATUS_MALFORMED;
        end
        else if (last_reg)
        begin
            dig_next    = hash;
            dvalid_next = 1'b1;
            chain_next  = amh_pkg::LEAF_DOMAIN;
            in_msg_next = 1'b0;
        end
        else
        begin
            chain_next  = hash;
            in_msg_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            chain_reg     <= amh_pkg::LEAF_DOMAIN;
            in_msg_reg    <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
                if (s1_valid_reg)
                begin
                    chain_reg  <= chain_next;
                    in_msg_reg <= in_msg_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free && in_valid)
        begin
            req_reg    <= req_type;
            blk_reg    <= {block_hi, block_lo};
            right_reg  <= {right_hi, right_lo};
            nbytes_reg <= block_bytes;
            last_reg   <= last_block;
        end
        if (advance && s1_valid_reg)
        begin
            dig_reg    <= dig_next;
            dvalid_reg <= dvalid_next;
            status_reg <= status_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign digest_hi    = dig_reg[127:64];
    assign digest_lo    = dig_reg[63:0];
    assign digest_valid = dvalid_reg;
    assign status       = status_reg;

    // A malformed result never carries a digest.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(digest_valid && status))
        else $error("digest and malformed status both set");

    // A digest-less ok result leaves a message in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !digest_valid && !status) |-> in_msg_reg)
        else $error("intermediate block did not mark message in progress");

    // Outside a message the chain sits at the leaf domain.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_msg_reg |-> (chain_reg == amh_pkg::LEAF_DOMAIN))
        else $error("chain not at leaf domain outside a message");

    // A held result stays put while the output is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(dig_reg)))
        else $error("stalled result changed");

endmodule
